>>> src/lpbgf_pkg.sv
// ----------------------------------------------------------------------------
// lpbgf_pkg
// Shared types, constants and the angle-to-bin function of the polar bin map.
// ----------------------------------------------------------------------------
package lpbgf_pkg;

  // Map geometry and field widths.
  localparam int NUM_BINS       = 360;
  localparam int FILL_REACH_DEF = 9;
  localparam int ADDR_W         = 9;
  localparam int DIST_W         = 16;
  localparam int ANGLE_W        = 16;
  localparam int DIST_Q2_W      = 18;
  localparam int FUNC_W         = 2;

  // Angle conversion: deg = (angle * 45 + 4096) >> 13.
  localparam int DEG_PROD_W = 22;
  localparam int DEG_MUL    = 45;
  localparam int DEG_ROUND  = 4096;
  localparam int DEG_SHIFT  = 13;
  localparam int HALF_TURN  = 180;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_CLEAR  = 2'd0,
    FUNC_NODE   = 2'd1,
    FUNC_FINISH = 2'd2,
    FUNC_READ   = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FILL,
    ST_READ
  } state_e;

  // One write request to the bin memory.
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [DIST_W-1:0] data;
  } mem_wr_t;

  // One word pushed into the gap fill window.
  typedef struct packed {
    logic              valid;
    logic [DIST_W-1:0] data;
  } win_push_t;

  // Rounded degree of a Q14 angle, turned into a bin where bin 0 is -180 degrees.
  // A rounded angle of 360 degrees lands on bin 180, the same as 0 degrees.
  function automatic logic [ADDR_W-1:0] node_bin(input logic [ANGLE_W-1:0] angle);
    logic [DEG_PROD_W-1:0] prod;
    logic [ADDR_W-1:0]     deg;
    prod = DEG_PROD_W'(angle) * DEG_PROD_W'(DEG_MUL) + DEG_PROD_W'(DEG_ROUND);
    deg  = prod[DEG_SHIFT +: ADDR_W];
    if (deg >= ADDR_W'(HALF_TURN)) begin
      node_bin = deg - ADDR_W'(HALF_TURN);
    end else begin
      node_bin = deg + ADDR_W'(HALF_TURN);
    end
  endfunction

endpackage

>>> src/lpbgf_in_if.sv
// ----------------------------------------------------------------------------
// lpbgf_in_if
// Command channel of the polar bin map: function code and node or read fields.
// ----------------------------------------------------------------------------
interface lpbgf_in_if;
  logic                             valid;
  logic                             ready;
  logic [lpbgf_pkg::FUNC_W-1:0]     func;
  logic [lpbgf_pkg::ANGLE_W-1:0]    angle_q14;
  logic [lpbgf_pkg::DIST_Q2_W-1:0]  dist_q2;
  logic [lpbgf_pkg::ADDR_W-1:0]     bin_index;

  modport source (output valid, func, angle_q14, dist_q2, bin_index, input ready);
  modport sink   (input valid, func, angle_q14, dist_q2, bin_index, output ready);
endinterface

>>> src/lpbgf_out_if.sv
// ----------------------------------------------------------------------------
// lpbgf_out_if
// Result channel of the polar bin map: the distance read from one bin.
// ----------------------------------------------------------------------------
interface lpbgf_out_if;
  logic                          valid;
  logic                          ready;
  logic [lpbgf_pkg::DIST_W-1:0]  distance_mm;

  modport source (output valid, distance_mm, input ready);
  modport sink   (input valid, distance_mm, output ready);
endinterface

>>> src/lpbgf_bin_mem.sv
// ----------------------------------------------------------------------------
// lpbgf_bin_mem
// Bin store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module lpbgf_bin_mem (
  input  logic                              clk_i,
  input  lpbgf_pkg::mem_wr_t                wr_i,
  input  logic                              rd_en_i,
  input  logic [lpbgf_pkg::ADDR_W-1:0]      rd_addr_i,
  output logic [lpbgf_pkg::DIST_W-1:0]      rd_data_o
);

  logic [lpbgf_pkg::DIST_W-1:0] mem_q [lpbgf_pkg::NUM_BINS];
  logic [lpbgf_pkg::DIST_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

  // A read in the same cycle as a write to the same entry returns the old word.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> src/lpbgf_fill_win.sv
// ----------------------------------------------------------------------------
// lpbgf_fill_win
// Sliding window over the bin being filled and its FILL_REACH successors.
// ----------------------------------------------------------------------------
module lpbgf_fill_win #(
  parameter int FILL_REACH = lpbgf_pkg::FILL_REACH_DEF
) (
  input  logic                          clk_i,
  input  lpbgf_pkg::win_push_t          push_i,
  output logic [lpbgf_pkg::DIST_W-1:0]  fill_o
);

  // Entry 0 is the bin under work, entry FILL_REACH the farthest neighbor.
  logic [lpbgf_pkg::DIST_W-1:0] win_q [FILL_REACH+1];

  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      for (int j = 0; j < FILL_REACH; j++) begin
        win_q[j] <= win_q[j+1];
      end
      win_q[FILL_REACH] <= push_i.data;
    end
  end

  // An empty bin takes the farthest nonzero neighbor; a set bin keeps its word.
  always_comb begin
    logic [lpbgf_pkg::DIST_W-1:0] far;
    far = '0;
    for (int j = 1; j <= FILL_REACH; j++) begin
      if (win_q[j] != '0) begin
        far = win_q[j];
      end
    end
    fill_o = (win_q[0] != '0) ? win_q[0] : far;
  end

endmodule

>>> src/lidar_polar_bin_gap_fill_unit.sv
// ----------------------------------------------------------------------------
// lidar_polar_bin_gap_fill_unit
// One-degree polar distance map built from lidar scan nodes, with gap fill.
// ----------------------------------------------------------------------------
// The map holds 360 bins of 16-bit millimetre distances in a single-port-write,
// single-port-read memory; bin 0 stands for -180 degrees. A node word is taken
// every cycle while the block is idle: its angle is rounded to whole degrees,
// turned into a bin and the distance (quarter millimetres shifted down by two)
// overwrites that bin when it is nonzero. A read word goes through the memory,
// which returns data in the cycle after the address, and into an output
// register; the result then waits there, and node words are taken again while
// it waits. A clear word sweeps the memory one bin per cycle, and the same
// clearing pass runs right after reset, during which no word is accepted. A
// finish word streams every bin, plus the first FILL_REACH bins once more for
// the wraparound, through a window of FILL_REACH+1 registers and writes each
// bin back in order, at one memory read per cycle. Wrapped neighbors are read
// after their own fill has been written, so the pass matches an in-place walk
// over the bins.
// ----------------------------------------------------------------------------
module lidar_polar_bin_gap_fill_unit #(
  parameter int FILL_REACH = lpbgf_pkg::FILL_REACH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  lpbgf_in_if.sink    in_i,
  lpbgf_out_if.source out_o
);

  localparam int CNT_W   = $clog2(lpbgf_pkg::NUM_BINS + FILL_REACH + 1);
  localparam int ADDR_W  = lpbgf_pkg::ADDR_W;
  localparam int DIST_W  = lpbgf_pkg::DIST_W;
  localparam int LAST_BIN = lpbgf_pkg::NUM_BINS - 1;

  lpbgf_pkg::state_e    state_q, state_d;
  lpbgf_pkg::func_e     func;
  lpbgf_pkg::mem_wr_t   mem_wr;
  lpbgf_pkg::win_push_t win_push;

  logic [ADDR_W-1:0] idx_q, idx_d;          // clear sweep and fill write index
  logic [CNT_W-1:0]  rd_cnt_q, rd_cnt_d;    // fill reads issued
  logic [CNT_W-1:0]  in_cnt_q, in_cnt_d;    // fill words shifted into the window
  logic              fill_rd_q, fill_rd_d;  // a fill read returns data this cycle
  logic              win_vld_q, win_vld_d;  // window holds a complete neighborhood
  logic              oor_q, oor_d;          // pending read was out of range
  logic              out_valid_q;
  logic [DIST_W-1:0] out_dist_q;
  logic              out_load;

  logic              in_accept;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] fill_rd_addr;
  logic [DIST_W-1:0] rd_data;
  logic [DIST_W-1:0] fill_val;
  logic [ADDR_W-1:0] node_bin;
  logic [DIST_W-1:0] node_dist;
  logic              read_oor;

  assign in_accept = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == lpbgf_pkg::ST_IDLE);
  assign func = lpbgf_pkg::func_e'(in_i.func);

  // Node conversion; an 18-bit quarter-millimetre value always fits 16 bits.
  assign node_bin  = lpbgf_pkg::node_bin(in_i.angle_q14);
  assign node_dist = in_i.dist_q2[lpbgf_pkg::DIST_Q2_W-1:2];
  assign read_oor  = (in_i.bin_index >= ADDR_W'(lpbgf_pkg::NUM_BINS));

  // Fill reads run over bins 0..359 and then again over 0..FILL_REACH-1.
  assign fill_rd_addr = (rd_cnt_q >= CNT_W'(lpbgf_pkg::NUM_BINS))
                      ? ADDR_W'(rd_cnt_q - CNT_W'(lpbgf_pkg::NUM_BINS))
                      : ADDR_W'(rd_cnt_q);

  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    rd_cnt_d  = rd_cnt_q;
    in_cnt_d  = in_cnt_q;
    fill_rd_d = 1'b0;
    oor_d     = oor_q;
    mem_wr    = '0;
    rd_en     = 1'b0;
    rd_addr   = '0;
    out_load  = 1'b0;

    unique case (state_q)
      lpbgf_pkg::ST_CLEAR: begin
        mem_wr.en   = 1'b1;
        mem_wr.addr = idx_q;
        mem_wr.data = '0;
        if (idx_q == ADDR_W'(LAST_BIN)) begin
          idx_d   = '0;
          state_d = lpbgf_pkg::ST_IDLE;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end

      lpbgf_pkg::ST_IDLE: begin
        if (in_accept) begin
          unique case (func)
            lpbgf_pkg::FUNC_CLEAR: begin
              idx_d   = '0;
              state_d = lpbgf_pkg::ST_CLEAR;
            end
            lpbgf_pkg::FUNC_NODE: begin
              mem_wr.en   = (node_dist != '0);
              mem_wr.addr = node_bin;
              mem_wr.data = node_dist;
            end
            lpbgf_pkg::FUNC_FINISH: begin
              idx_d    = '0;
              rd_cnt_d = '0;
              in_cnt_d = '0;
              state_d  = lpbgf_pkg::ST_FILL;
            end
            lpbgf_pkg::FUNC_READ: begin
              rd_en   = 1'b1;
              rd_addr = read_oor ? '0 : in_i.bin_index;
              oor_d   = read_oor;
              state_d = lpbgf_pkg::ST_READ;
            end
            default: begin
              state_d = lpbgf_pkg::ST_IDLE;
            end
          endcase
        end
      end

      lpbgf_pkg::ST_FILL: begin
        if (rd_cnt_q < CNT_W'(lpbgf_pkg::NUM_BINS + FILL_REACH)) begin
          rd_en     = 1'b1;
          rd_addr   = fill_rd_addr;
          fill_rd_d = 1'b1;
          rd_cnt_d  = rd_cnt_q + 1'b1;
        end
        if (fill_rd_q) begin
          in_cnt_d = in_cnt_q + 1'b1;
        end
        if (win_vld_q) begin
          mem_wr.en   = 1'b1;
          mem_wr.addr = idx_q;
          mem_wr.data = fill_val;
          if (idx_q == ADDR_W'(LAST_BIN)) begin
            idx_d   = '0;
            state_d = lpbgf_pkg::ST_IDLE;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
      end

      lpbgf_pkg::ST_READ: begin
        // The read word stays in the memory's data register until the output
        // register is free.
        if (!out_valid_q || out_o.ready) begin
          out_load = 1'b1;
          state_d  = lpbgf_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = lpbgf_pkg::ST_IDLE;
      end
    endcase
  end

  // The window is complete once the word FILL_REACH places ahead has arrived.
  assign win_vld_d = fill_rd_q && (in_cnt_q >= CNT_W'(FILL_REACH));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= lpbgf_pkg::ST_CLEAR;
      idx_q     <= '0;
      rd_cnt_q  <= '0;
      in_cnt_q  <= '0;
      fill_rd_q <= 1'b0;
      win_vld_q <= 1'b0;
      oor_q     <= 1'b0;
    end else begin
      state_q   <= state_d;
      idx_q     <= idx_d;
      rd_cnt_q  <= rd_cnt_d;
      in_cnt_q  <= in_cnt_d;
      fill_rd_q <= fill_rd_d;
      win_vld_q <= win_vld_d;
      oor_q     <= oor_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_dist_q <= oor_q ? '0 : rd_data;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.distance_mm = out_dist_q;

  assign win_push.valid = fill_rd_q;
  assign win_push.data  = rd_data;

  lpbgf_bin_mem u_bin_mem (
    .clk_i     (clk_i),
    .wr_i      (mem_wr),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  lpbgf_fill_win #(
    .FILL_REACH (FILL_REACH)
  ) u_fill_win (
    .clk_i  (clk_i),
    .push_i (win_push),
    .fill_o (fill_val)
  );

endmodule

>>> src/lpbgf_checker.sv
// ----------------------------------------------------------------------------
// lpbgf_checker
// Port-level checks of the polar bin map, bound to the top level.
// ----------------------------------------------------------------------------
module lpbgf_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_ready_i,
  input logic [lpbgf_pkg::FUNC_W-1:0]      in_func_i,
  input logic                              out_valid_i,
  input logic                              out_ready_i,
  input logic [lpbgf_pkg::DIST_W-1:0]      out_distance_mm_i
);

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_i;

  // A new result comes from a read word via the data and output registers.
  a_out_from_read : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_acc && (in_func_i == lpbgf_pkg::FUNC_READ), 2))
    else $error("result word without a matching read word");

  // Clear and finish occupy the block, so the next cycle takes no word.
  a_busy_after_sweep : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_func_i == lpbgf_pkg::FUNC_CLEAR || in_func_i == lpbgf_pkg::FUNC_FINISH)
    |=> !in_ready_i)
    else $error("word accepted right after a clear or finish word");

  // A node word leaves the block ready for the next word.
  a_node_back_to_back : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_func_i == lpbgf_pkg::FUNC_NODE) |=> in_ready_i)
    else $error("node word stalled the command channel");

  // A result word that is not taken holds its value.
  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_distance_mm_i))
    else $error("stalled result word changed");

endmodule

bind lidar_polar_bin_gap_fill_unit lpbgf_checker u_lpbgf_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_i.valid),
  .in_ready_i        (in_i.ready),
  .in_func_i         (in_i.func),
  .out_valid_i       (out_o.valid),
  .out_ready_i       (out_o.ready),
  .out_distance_mm_i (out_o.distance_mm)
);

>>> verif/lidar_polar_bin_gap_fill_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lidar_polar_bin_gap_fill_unit_tb
// Self-checking bench for the polar bin map with gap fill.
// ----------------------------------------------------------------------------
// A queue of command words is built at time zero. It starts with a directed
// opening and continues with random scan sequences: clear, nodes, finish and
// reads. A clocked driver feeds the words to the block. A clocked monitor
// collects the read results. Every accepted word also updates a shadow copy of
// the 360-bin map, and each read pushes its expected distance. The monitor
// compares each returned distance with the oldest expected one. Both sides
// throttle at random in three phases, the last of which runs at full rate.
// ----------------------------------------------------------------------------
module lidar_polar_bin_gap_fill_unit_tb;
  import lpbgf_pkg::*;

  localparam int FILL_REACH    = FILL_REACH_DEF;
  localparam int CLK_HALF_NS   = 10;
  localparam int ITEM_TARGET   = 1550;
  // DRAIN_CYCLES covers the block finishing a finish pass or a clear sweep
  // that may still be running at the end.
  localparam int DRAIN_CYCLES  = 400;
  localparam int SWEEP_COST    = 400;
  localparam int WORD_COST     = 4;
  localparam int HANDSHAKE_GAP = 40;
  localparam int LIMIT_SCALE   = 4;

  // Idle and stall rates, in percent, for the three pacing phases.
  localparam int SLOW_PCT = 76;
  localparam int FAST_PCT = 22;

  // One command word as the bench sees it.
  typedef struct {
    func_e                 func;
    logic [ANGLE_W-1:0]    angle_q14;
    logic [DIST_Q2_W-1:0]  dist_q2;
    logic [ADDR_W-1:0]     bin_index;
  } map_word_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  lpbgf_in_if  cmd_if ();
  lpbgf_out_if dist_if ();

  lidar_polar_bin_gap_fill_unit #(
    .FILL_REACH(FILL_REACH)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (cmd_if),
    .out_o (dist_if)
  );

  always #(CLK_HALF_NS) clk_i = ~clk_i;

  // Shadow map, words still to send, and distances the reads must return.
  logic [DIST_W-1:0] bin_map [NUM_BINS];
  map_word_t         pending_words [$];
  logic [DIST_W-1:0] read_expect [$];
  map_word_t         held_word;

  int unsigned n_accepted   = 0;
  int unsigned n_total      = 0;
  int unsigned n_errors     = 0;
  int unsigned work_budget  = 0;
  int unsigned cycle_count  = 0;
  int unsigned cycle_limit  = 32'hFFFF_FFFF;

  // Pacing follows the share of words accepted so far: the sender is fast
  // while the receiver is slow first, then the other way round, then neither
  // side holds back.
  logic [1:0]  pace_phase;
  int unsigned send_idle;
  int unsigned recv_stall;

  assign pace_phase = (n_accepted * 3 < n_total)     ? 2'd0 :
                      (n_accepted * 3 < 2 * n_total) ? 2'd1 : 2'd2;
  assign send_idle  = (pace_phase == 2'd0) ? FAST_PCT :
                      (pace_phase == 2'd1) ? SLOW_PCT : 0;
  assign recv_stall = (pace_phase == 2'd0) ? SLOW_PCT :
                      (pace_phase == 2'd1) ? FAST_PCT : 0;

  // --------------------------------------------------------------------------
  // Shadow map update, run once per accepted word in acceptance order.
  // --------------------------------------------------------------------------
  task automatic update_bin_map(input map_word_t w);
    int unsigned       deg;
    int unsigned       bin;
    int                i;
    int                j;
    logic [DIST_W-1:0] mm;
    case (w.func)
      FUNC_CLEAR: begin
        foreach (bin_map[k]) bin_map[k] = '0;
      end
      FUNC_NODE: begin
        // Round the Q14 angle to whole degrees; 360 wraps to 0, then the
        // map is shifted so that bin 0 is -180 degrees.
        deg = (32'(w.angle_q14) * DEG_MUL + DEG_ROUND) >> DEG_SHIFT;
        bin = ((deg % NUM_BINS) + HALF_TURN) % NUM_BINS;
        // An 18-bit quarter-millimetre value shifted by two always fits in 16 bits.
        mm = w.dist_q2[DIST_Q2_W-1:2];
        if (mm != '0) begin
          bin_map[bin] = mm;
        end
      end
      FUNC_FINISH: begin
        // In-place walk: an empty bin takes the last nonzero value among
        // the next FILL_REACH bins, so the farthest one wins. Bins filled
        // earlier in the walk count when reached through the wraparound.
        for (i = 0; i < NUM_BINS; i++) begin
          if (bin_map[i] == '0) begin
            for (j = 1; j <= FILL_REACH; j++) begin
              if (bin_map[(i + j) % NUM_BINS] != '0) begin
                bin_map[i] = bin_map[(i + j) % NUM_BINS];
              end
            end
          end
        end
      end
      default: begin
        // Reads past the last bin return zero.
        read_expect.push_back((w.bin_index < NUM_BINS) ? bin_map[w.bin_index] : '0);
      end
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Stimulus helpers.
  // --------------------------------------------------------------------------
  task automatic push_word(input func_e f, input logic [ANGLE_W-1:0] angle,
                           input logic [DIST_Q2_W-1:0] dist_val,
                           input logic [ADDR_W-1:0] idx);
    map_word_t w;
    w.func      = f;
    w.angle_q14 = angle;
    w.dist_q2   = dist_val;
    w.bin_index = idx;
    pending_words.push_back(w);
    work_budget += HANDSHAKE_GAP +
                   (((f == FUNC_CLEAR) || (f == FUNC_FINISH)) ? SWEEP_COST : WORD_COST);
  endtask

  // Mostly valid distances, with some invalid ones (zero, or below one
  // millimetre) and some at the top of the range.
  function automatic logic [DIST_Q2_W-1:0] rand_dist();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 5) begin
      rand_dist = '0;
    end else if (r < 10) begin
      rand_dist = DIST_Q2_W'($urandom_range(3, 1));
    end else if (r < 15) begin
      rand_dist = DIST_Q2_W'($urandom_range(262143, 262140));
    end else if (r < 55) begin
      rand_dist = DIST_Q2_W'($urandom_range(262143, 4));
    end else begin
      rand_dist = DIST_Q2_W'($urandom_range(20000, 4));
    end
  endfunction

  // Read index: mostly a real bin, sometimes past the end of the map.
  function automatic logic [ADDR_W-1:0] rand_bin();
    if ($urandom_range(99) < 6) begin
      rand_bin = ADDR_W'($urandom_range(511, NUM_BINS));
    end else begin
      rand_bin = ADDR_W'($urandom_range(NUM_BINS - 1));
    end
  endfunction

  // --------------------------------------------------------------------------
  // Driver: presents the next word, holds it until ready, and updates the
  // shadow map at the edge where the word is taken.
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_if.valid     <= 1'b0;
      cmd_if.func      <= FUNC_CLEAR;
      cmd_if.angle_q14 <= '0;
      cmd_if.dist_q2   <= '0;
      cmd_if.bin_index <= '0;
    end else begin
      if (cmd_if.valid && cmd_if.ready) begin
        update_bin_map(held_word);
        n_accepted <= n_accepted + 1;
      end
      if (!cmd_if.valid || cmd_if.ready) begin
        if ((pending_words.size() != 0) && ($urandom_range(99) >= send_idle)) begin
          held_word         = pending_words.pop_front();
          cmd_if.valid     <= 1'b1;
          cmd_if.func      <= held_word.func;
          cmd_if.angle_q14 <= held_word.angle_q14;
          cmd_if.dist_q2   <= held_word.dist_q2;
          cmd_if.bin_index <= held_word.bin_index;
        end else begin
          cmd_if.valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: takes read results under a random ready and checks each one
  // against the oldest expected distance.
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dist_if.ready <= 1'b0;
    end else begin
      if (dist_if.valid && dist_if.ready) begin
        if (read_expect.size() == 0) begin
          $display("%0t: distance word with no read pending, expected none, got %0d",
                   $time, dist_if.distance_mm);
          n_errors++;
        end else if (read_expect[0] !== dist_if.distance_mm) begin
          $display("%0t: distance_mm mismatch, expected %0d, got %0d",
                   $time, read_expect[0], dist_if.distance_mm);
          n_errors++;
          void'(read_expect.pop_front());
        end else begin
          void'(read_expect.pop_front());
        end
      end
      dist_if.ready <= ($urandom_range(99) >= recv_stall);
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= cycle_limit) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("lidar_polar_bin_gap_fill_unit verification failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of run.
  // --------------------------------------------------------------------------
  initial begin
    int unsigned seq_kind;
    int unsigned n;
    int unsigned k;

    // The driver and the monitor set their own outputs while reset is low.
    rst_ni <= 1'b0;
    foreach (bin_map[i]) bin_map[i] = '0;

    // Directed opening. The map is empty after the reset clearing pass.
    push_word(FUNC_READ,   16'hFFFF, '1, 9'd0);
    push_word(FUNC_READ,   16'h0000, '0, 9'd359);
    // Angle zero lands on bin 180; the largest distance gives 65535 mm.
    push_word(FUNC_NODE,   16'd0, 18'd262143, 9'd0);
    push_word(FUNC_READ,   16'd0, 18'd0, 9'd180);
    // The largest angle rounds to 360 degrees and wraps onto bin 180 too.
    push_word(FUNC_NODE,   16'd65535, 18'd4, 9'd511);
    push_word(FUNC_READ,   16'd0, 18'd0, 9'd180);
    // 179 degrees is the last bin.
    push_word(FUNC_NODE,   16'd32496, 18'd400, 9'd0);
    // 22.5 degrees exactly: the half rounds up to 23, bin 203.
    push_word(FUNC_NODE,   16'd4096, 18'd800, 9'd0);
    // Below one millimetre and zero distance leave the map alone.
    push_word(FUNC_NODE,   16'd2, 18'd3, 9'd0);
    push_word(FUNC_NODE,   16'd16384, 18'd0, 9'd0);
    push_word(FUNC_READ,   16'd0, 18'd0, 9'd203);
    push_word(FUNC_READ,   16'd0, 18'd0, 9'd180);
    // Reads past the end of the map.
    push_word(FUNC_READ,   16'd0, 18'd0, 9'd360);
    push_word(FUNC_READ,   16'd0, 18'd0, 9'd511);
    push_word(FUNC_FINISH, 16'd0, 18'd0, 9'd0);
    // Bin 2 feeds bins 0 and 1; the bins just below 359 already hold values
    // from the earlier finish word and keep them.
    push_word(FUNC_NODE,   16'd33042, 18'd40, 9'd0);
    push_word(FUNC_FINISH, 16'd0, 18'd0, 9'd0);
    push_word(FUNC_READ,   16'd0, 18'd0, 9'd355);
    push_word(FUNC_READ,   16'd0, 18'd0, 9'd0);
    push_word(FUNC_READ,   16'd0, 18'd0, 9'd175);
    push_word(FUNC_CLEAR,  16'd0, 18'd0, 9'd0);
    push_word(FUNC_READ,   16'd0, 18'd0, 9'd359);
    // Gap fill on an empty map keeps it empty.
    push_word(FUNC_FINISH, 16'd0, 18'd0, 9'd0);
    push_word(FUNC_READ,   16'd0, 18'd0, 9'd100);

    // Random part. Most of it is whole scans: an optional clear, a sparse or
    // dense burst of nodes, the gap fill and a batch of reads. The rest mixes
    // nodes with reads, or is noise with any function code.
    while (pending_words.size() < ITEM_TARGET) begin
      seq_kind = $urandom_range(99);
      if (seq_kind < 70) begin
        if ($urandom_range(1)) begin
          push_word(FUNC_CLEAR, 16'($urandom_range(65535)), rand_dist(), rand_bin());
        end
        n = ($urandom_range(3) == 0) ? $urandom_range(120, 30) : $urandom_range(8, 1);
        for (k = 0; k < n; k++) begin
          push_word(FUNC_NODE, 16'($urandom_range(65535)), rand_dist(), rand_bin());
        end
        push_word(FUNC_FINISH, 16'($urandom_range(65535)), rand_dist(), rand_bin());
        n = $urandom_range(20, 4);
        for (k = 0; k < n; k++) begin
          push_word(FUNC_READ, 16'($urandom_range(65535)), rand_dist(), rand_bin());
        end
      end else if (seq_kind < 90) begin
        n = $urandom_range(40, 10);
        for (k = 0; k < n; k++) begin
          push_word($urandom_range(1) ? FUNC_NODE : FUNC_READ,
                    16'($urandom_range(65535)), rand_dist(), rand_bin());
        end
      end else begin
        n = $urandom_range(6, 1);
        for (k = 0; k < n; k++) begin
          push_word(func_e'($urandom_range(3)), 16'($urandom_range(65535)),
                    rand_dist(), ADDR_W'($urandom_range(511)));
        end
      end
    end
    // End on a read so the last map state is seen.
    push_word(FUNC_READ, 16'($urandom_range(65535)), rand_dist(), rand_bin());

    n_total     = pending_words.size();
    cycle_limit = LIMIT_SCALE * (work_budget + DRAIN_CYCLES + 2 * SWEEP_COST);

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait for every word to be taken, then for every read to return, then
    // long enough for a stray result to show up.
    while ((pending_words.size() != 0) || cmd_if.valid) @(posedge clk_i);
    while (read_expect.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (n_errors == 0) begin
      $display("lidar_polar_bin_gap_fill_unit verification clean");
    end else begin
      $display("lidar_polar_bin_gap_fill_unit verification failed");
    end
    $finish;
  end

endmodule

>>> lidar_polar_bin_gap_fill_unit.f
src/lpbgf_pkg.sv
src/lpbgf_in_if.sv
src/lpbgf_out_if.sv
src/lpbgf_bin_mem.sv
src/lpbgf_fill_win.sv
src/lidar_polar_bin_gap_fill_unit.sv
src/lpbgf_checker.sv
verif/lidar_polar_bin_gap_fill_unit_tb.sv
